@@ sv/s512_pkg.sv @@
package s512_pkg;

    // Working variables a..h, index 0 is a
    typedef logic [7:0][63:0] t_vars;

    localparam int ROUNDS     = 80;
    localparam int LEN_POS    = 14;
    localparam int PAD_BYTE   = 128;
    localparam int BLOCK_BITS = 1024; // 1024-bit block

    // Controller states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    // Pending padding words
    localparam logic [2:0] P_NONE = 3'd0;
    localparam logic [2:0] P_X80  = 3'd1;
    localparam logic [2:0] P_ZERO = 3'd2;
    localparam logic [2:0] P_HI   = 3'd3;
    localparam logic [2:0] P_LO   = 3'd4;
    localparam logic [2:0] P_EMIT = 3'd5;

    // Round phases
    localparam logic [1:0] PH_RD0  = 2'd0;
    localparam logic [1:0] PH_RD1  = 2'd1;
    localparam logic [1:0] PH_SUM  = 2'd2;
    localparam logic [1:0] PH_STEP = 2'd3;

    localparam logic [0:7][63:0] IV = {
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B, 64'h3C6EF372FE94F82B,
        64'hA54FF53A5F1D36F1, 64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [0:79][63:0] KTAB = {
        64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
        64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
        64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
        64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
        64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
        64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
        64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
        64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
        64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
        64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
        64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
        64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
        64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
        64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
        64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
        64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
        64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
        64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
        64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
        64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    // Schedule sigmas
    function automatic logic [63:0] ssig0(input logic [63:0] x);
        ssig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic logic [63:0] ssig1(input logic [63:0] x);
        ssig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    // Round sigmas
    function automatic logic [63:0] bsig0(input logic [63:0] x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic logic [63:0] bsig1(input logic [63:0] x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

endpackage

@@ sv/s512_if.sv @@
// Message word channel
interface s512_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] msg_word;
    logic [3:0]  byte_count;
    logic        final_word;

    modport source (output valid, output msg_word, output byte_count, output final_word,
                    input ready);
    modport sink (input valid, input msg_word, input byte_count, input final_word,
                  output ready);
endinterface

// Digest word channel
interface s512_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_of_digest;

    modport source (output valid, output digest_word, output word_index,
                    output last_of_digest, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_of_digest, output ready);
endinterface

@@ sv/sha512_hash_engine.sv @@
// SHA-512 hash engine.
// Input channel i_msg carries 64-bit message words, first byte in bits 63..56.
// byte_count (0..8, larger values clamp to 8) gives the valid leading bytes
// of the word marked final_word; on other words it is ignored. Output
// channel o_dig returns the eight digest words H0..H7 with word_index and
// last_of_digest on H7. Each word is stored into a 16-entry schedule RAM;
// the sixteenth word of a block starts a compression. It loads a..h from
// the hash RAM, runs 80 rounds of PH_RD0, PH_RD1 and PH_STEP (rounds 16..79
// add PH_SUM, which sums the two schedule RAM read ports into the new word)
// and adds back. Input is not accepted during compression. A final word
// adds padding pushes and one or two compressions, then each digest word
// is read from the hash RAM.
// Synchronous reset returns the hash to the initial values (valid bits over
// the hash RAM, no clearing pass) and drops any partial block. A stalled
// receiver holds the digest in the output register; the engine then waits.
// After the last digest word is taken into the output register the engine
// starts a fresh message and accepts input again.
module sha512_hash_engine import s512_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    s512_in_if.sink    i_msg,
    s512_out_if.source o_dig
);
    // Control registers
    logic [2:0]  r_state, n_state;
    logic [2:0]  r_pend, n_pend;
    logic [3:0]  r_wib, n_wib;
    logic [63:0] r_len, n_len;
    logic [3:0]  r_cnt, n_cnt;
    logic [6:0]  r_t, n_t;
    logic [1:0]  r_ph, n_ph;
    logic [2:0]  r_k, n_k;
    logic [7:0]  r_hval, n_hval;
    logic        r_hv_q;
    logic [2:0]  r_haddr_q;

    // Datapath registers
    t_vars       r_v, n_v;
    logic [63:0] r_s, n_s;
    logic [63:0] r_wt, n_wt;
    logic        r_ovld, n_ovld;
    logic [63:0] r_odata, n_odata;
    logic [2:0]  r_oidx, n_oidx;

    // RAM ports
    logic        s_we;
    logic [3:0]  s_waddr, s_ra0, s_ra1;
    logic [63:0] s_wdata, s_rd0, s_rd1;
    logic        h_we;
    logic [2:0]  h_waddr, h_raddr;
    logic [63:0] h_wdata, h_rd, h_q;

    t_vars       v_rnd;
    logic [3:0]  nb;
    logic [6:0]  nb_sh;
    logic [63:0] in_word;
    logic [63:0] push_word;
    logic        push;

    s512_ram #(.WIDTH(64), .DEPTH(16)) u_sched (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr_a(s_ra0), .i_raddr_b(s_ra1), .o_rdata_a(s_rd0), .o_rdata_b(s_rd1)
    );

    s512_ram #(.WIDTH(64), .DEPTH(8)) u_hash (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr_a(h_raddr), .i_raddr_b(3'd0), .o_rdata_a(h_rd), .o_rdata_b()
    );

    s512_round u_round (.i_v(r_v), .i_wt(r_wt), .i_k(KTAB[r_t]), .o_v(v_rnd));

    // Hash entry not yet written reads as its initial value
    assign h_q = r_hv_q ? h_rd : IV[r_haddr_q];

    // Final word: clamp count, keep leading bytes, append 0x80 if not full
    always_comb begin
        nb      = (i_msg.byte_count > 4'd8) ? 4'd8 : i_msg.byte_count;
        nb_sh   = {nb, 3'b000};
        in_word = i_msg.msg_word;
        if (i_msg.final_word && nb != 4'd8) begin
            in_word = (i_msg.msg_word & ~(64'hFFFF_FFFF_FFFF_FFFF >> nb_sh))
                    | (64'h8000_0000_0000_0000 >> nb_sh);
        end
    end

    assign i_msg.ready          = (r_state == S_IDLE);
    assign o_dig.valid          = r_ovld;
    assign o_dig.digest_word    = r_odata;
    assign o_dig.word_index     = r_oidx;
    assign o_dig.last_of_digest = (r_oidx == 3'd7);

    // Main sequencer
    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        n_wib   = r_wib;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_t     = r_t;
        n_ph    = r_ph;
        n_k     = r_k;
        n_hval  = r_hval;
        n_v     = r_v;
        n_s     = r_s;
        n_wt    = r_wt;
        n_ovld  = r_ovld && !o_dig.ready;
        n_odata = r_odata;
        n_oidx  = r_oidx;

        push      = 1'b0;
        push_word = 64'd0;
        s_ra0     = 4'd0;
        s_ra1     = 4'd0;
        s_we      = 1'b0;
        s_waddr   = r_wib;
        s_wdata   = 64'd0;
        h_we      = 1'b0;
        h_waddr   = r_haddr_q;
        h_wdata   = h_q + r_v[0];
        h_raddr   = r_cnt[2:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_msg.valid) begin
                    push      = 1'b1;
                    push_word = in_word;
                    n_len     = r_len + (i_msg.final_word ? {60'd0, nb} : 64'd8);
                    if (i_msg.final_word) begin
                        n_pend  = (nb == 4'd8) ? P_X80 : P_ZERO;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                unique case (r_pend)
                    P_X80: begin
                        push      = 1'b1;
                        push_word = 64'h8000_0000_0000_0000;
                        n_pend    = P_ZERO;
                    end
                    P_ZERO: begin
                        if (r_wib == 4'(LEN_POS)) begin
                            n_pend = P_HI;
                        end else begin
                            push = 1'b1;
                        end
                    end
                    P_HI: begin
                        push      = 1'b1;
                        push_word = {61'd0, r_len[63:61]};
                        n_pend    = P_LO;
                    end
                    P_LO: begin
                        push      = 1'b1;
                        push_word = {r_len[60:0], 3'b000};
                        n_pend    = P_EMIT;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_LOAD: begin
                if (r_cnt != 4'd0) begin
                    n_v = {h_q, r_v[7:1]};
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd8) begin
                    n_state = S_RND;
                    n_t     = 7'd0;
                    n_ph    = PH_RD0;
                end
            end
            S_RND: begin
                unique case (r_ph)
                    PH_RD0: begin
                        s_ra0 = (r_t < 7'd16) ? r_t[3:0] : 4'(r_t - 7'd15);
                        s_ra1 = 4'(r_t - 7'd2);
                        n_ph  = PH_RD1;
                    end
                    PH_RD1: begin
                        s_ra0 = r_t[3:0];
                        s_ra1 = 4'(r_t - 7'd7);
                        if (r_t < 7'd16) begin
                            n_wt = s_rd0;
                            n_ph = PH_STEP;
                        end else begin
                            n_s  = ssig0(s_rd0) + ssig1(s_rd1);
                            n_ph = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        n_wt    = r_s + s_rd0 + s_rd1;
                        s_we    = 1'b1;
                        s_waddr = r_t[3:0];
                        s_wdata = n_wt;
                        n_ph    = PH_STEP;
                    end
                    default: begin
                        n_v  = v_rnd;
                        n_t  = r_t + 7'd1;
                        n_ph = PH_RD0;
                        if (r_t == 7'(ROUNDS - 1)) begin
                            n_state = S_ADD;
                            n_cnt   = 4'd0;
                        end
                    end
                endcase
            end
            S_ADD: begin
                if (r_cnt != 4'd0) begin
                    h_we             = 1'b1;
                    n_hval[r_haddr_q] = 1'b1;
                    n_v              = {r_v[0], r_v[7:1]};
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd8) begin
                    unique case (r_pend)
                        P_EMIT: begin
                            n_state = S_EMIT;
                            n_k     = 3'd0;
                            n_ph    = PH_RD0;
                        end
                        P_NONE:  n_state = S_IDLE;
                        default: n_state = S_PAD;
                    endcase
                end
            end
            default: begin
                // Digest read-out: PH_RD0 reads, PH_RD1 loads the output
                h_raddr = r_k;
                if (r_ph == PH_RD0) begin
                    n_ph = PH_RD1;
                end else if (!r_ovld || o_dig.ready) begin
                    n_ovld  = 1'b1;
                    n_odata = h_q;
                    n_oidx  = r_k;
                    n_k     = r_k + 3'd1;
                    n_ph    = PH_RD0;
                    if (r_k == 3'd7) begin
                        n_state = S_IDLE;
                        n_pend  = P_NONE;
                        n_hval  = 8'd0;
                        n_wib   = 4'd0;
                        n_len   = 64'd0;
                    end
                end
            end
        endcase

        // Word store; a full block starts a compression
        if (push) begin
            s_we    = 1'b1;
            s_waddr = r_wib;
            s_wdata = push_word;
            n_wib   = r_wib + 4'd1;
            if (r_wib == 4'd15) begin
                n_state = S_LOAD;
                n_cnt   = 4'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= P_NONE;
            r_wib   <= 4'd0;
            r_len   <= 64'd0;
            r_cnt   <= 4'd0;
            r_t     <= 7'd0;
            r_ph    <= PH_RD0;
            r_k     <= 3'd0;
            r_hval  <= 8'd0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_wib   <= n_wib;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_t     <= n_t;
            r_ph    <= n_ph;
            r_k     <= n_k;
            r_hval  <= n_hval;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hv_q    <= r_hval[h_raddr] && i_rst_n;
        r_haddr_q <= h_raddr;
        r_v       <= n_v;
        r_s       <= n_s;
        r_wt      <= n_wt;
        r_odata   <= n_odata;
        r_oidx    <= n_oidx;
    end
endmodule

@@ sv/s512_ram.sv @@
// Simple dual-read RAM, one write port, registered reads
module s512_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

@@ sv/s512_round.sv @@
// One SHA-512 compression round
module s512_round import s512_pkg::*; (
    input  t_vars       i_v,
    input  logic [63:0] i_wt,
    input  logic [63:0] i_k,
    output t_vars       o_v
);
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] ch;
    logic [63:0] maj;

    always_comb begin
        ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        t1  = i_v[7] + bsig1(i_v[4]) + ch + i_k + i_wt;
        t2  = bsig0(i_v[0]) + maj;
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = t1 + t2;
    end
endmodule

@@ tb/sv/tb_sha512_hash_engine.sv @@
`timescale 1ns / 100ps

module tb_sha512_hash_engine;
    import s512_pkg::*;

    typedef struct {
        logic [63:0] msg_word;
        logic [3:0]  byte_count;
        logic        final_word;
    } t_word_item;

    typedef struct {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } t_digest_item;

    // Known-answer digest word 0 of the empty message
    localparam logic [63:0] EMPTY_H0 = 64'hCF83E1357EEFB8BD;
    localparam int          LIMIT_CYCLES = 900000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    s512_in_if  msg_if ();
    s512_out_if dig_if ();

    sha512_hash_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_msg   (msg_if.sink),
        .o_dig   (dig_if.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [63:0] hash_st [8];
    logic [63:0] blk_buf [16];
    int unsigned blk_fill;
    logic [63:0] msg_bytes;

    t_digest_item digest_q [$];
    int           err_cnt = 0;
    int           dig_cnt = 0;
    int           cyc = 0;
    bit           no_idle = 1'b0;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic hash_init();
        hash_st[0] = 64'h6A09E667F3BCC908; hash_st[1] = 64'hBB67AE8584CAA73B;
        hash_st[2] = 64'h3C6EF372FE94F82B; hash_st[3] = 64'hA54FF53A5F1D36F1;
        hash_st[4] = 64'h510E527FADE682D1; hash_st[5] = 64'h9B05688C2B3E6C1F;
        hash_st[6] = 64'h1F83D9ABFB41BD6B; hash_st[7] = 64'h5BE0CD19137E2179;
        blk_fill = 0;
        msg_bytes = '0;
    endtask

    // 80-round compression of blk_buf into hash_st
    task automatic compress();
        logic [63:0] v [8];
        logic [63:0] w [80];
        logic [63:0] t1, t2;
        for (int t = 0; t < 80; t++) begin
            if (t < 16) w[t] = blk_buf[t];
            else w[t] = w[t-16] + (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7))
                      + w[t-7] + (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6));
        end
        for (int j = 0; j < 8; j++) v[j] = hash_st[j];
        for (int t = 0; t < 80; t++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[t] + w[t];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_st[j] += v[j];
    endtask

    task automatic store_word(logic [63:0] w);
        blk_buf[blk_fill] = w;
        blk_fill = (blk_fill + 1) % 16;
        if (blk_fill == 0) compress();
    endtask

    // Predict digest words caused by one accepted item
    task automatic predict_word(t_word_item it);
        int unsigned nb;
        logic [63:0] keep, len_bytes;
        t_digest_item d;
        if (!it.final_word) begin
            msg_bytes += 8;
            store_word(it.msg_word);
            return;
        end
        nb = (it.byte_count > 8) ? 8 : it.byte_count;
        msg_bytes += nb;
        if (nb == 8) begin
            store_word(it.msg_word);
            store_word(64'h8000000000000000);
        end else begin
            keep = (nb == 0) ? 64'h0 : ~64'h0 << (64 - 8 * nb);
            store_word((it.msg_word & keep) | (64'h80 << (56 - 8 * nb)));
        end
        len_bytes = msg_bytes;
        if (blk_fill > 14) while (blk_fill != 0) store_word(64'h0);
        while (blk_fill < 14) store_word(64'h0);
        store_word(len_bytes >> 61);
        store_word(len_bytes << 3);
        for (int k = 0; k < 8; k++) begin
            d.digest_word = hash_st[k];
            d.word_index = k[2:0];
            d.last_of_digest = (k == 7);
            digest_q.push_back(d);
        end
        hash_init();
    endtask

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random stall, compare at rising edge
    initial dig_if.ready = 1'b0;
    always @(negedge i_clk) begin
        dig_if.ready <= no_idle || ($urandom_range(99) >= 13);
    end

    always @(posedge i_clk) begin
        t_digest_item e;
        if (i_rst_n && dig_if.valid && dig_if.ready) begin
            // First digest is the empty message: known answer for word 0
            if (dig_cnt == 0 && dig_if.digest_word !== EMPTY_H0) begin
                $error("digest_word exp %h got %h", EMPTY_H0, dig_if.digest_word);
                err_cnt++;
            end
            dig_cnt++;
            if (digest_q.size() == 0) begin
                $error("unexpected digest word %h", dig_if.digest_word);
                err_cnt++;
            end else begin
                e = digest_q.pop_front();
                if (dig_if.digest_word !== e.digest_word) begin
                    $error("digest_word exp %h got %h", e.digest_word, dig_if.digest_word);
                    err_cnt++;
                end
                if (dig_if.word_index !== e.word_index) begin
                    $error("word_index exp %0d got %0d", e.word_index, dig_if.word_index);
                    err_cnt++;
                end
                if (dig_if.last_of_digest !== e.last_of_digest) begin
                    $error("last_of_digest exp %0d got %0d", e.last_of_digest,
                           dig_if.last_of_digest);
                    err_cnt++;
                end
            end
        end
    end

    // Send one item; predict at acceptance
    task automatic send_word(t_word_item it);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 13) begin
            msg_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        msg_if.valid      <= 1'b1;
        msg_if.msg_word   <= it.msg_word;
        msg_if.byte_count <= it.byte_count;
        msg_if.final_word <= it.final_word;
        do @(posedge i_clk); while (!msg_if.ready);
        predict_word(it);
    endtask

    // Drop valid before the sender pauses
    task automatic hold_input();
        @(negedge i_clk);
        msg_if.valid <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Directed rows: {word, count, final}
    t_word_item dir_tab [] = '{
        '{64'h0, 4'd0, 1'b1},                          // empty message
        '{64'hFFFFFFFFFFFFFFFF, 4'd8, 1'b1},           // full final word
        '{64'hFFFFFFFFFFFFFFFF, 4'd15, 1'b1},          // count above eight
        '{64'h0123456789ABCDEF, 4'd3, 1'b0},           // short non-final
        '{64'hFFFFFFFFFFFFFFFF, 4'd7, 1'b1},
        '{64'h0, 4'd1, 1'b1},
        '{64'hFFFFFFFFFFFFFFFF, 4'd9, 1'b0},
        '{64'hA5A5A5A55A5A5A5A, 4'd4, 1'b1}
    };

    initial begin
        t_word_item it;
        int n_sent, len, n_msg;
        msg_if.valid = 1'b0;
        msg_if.msg_word = '0;
        msg_if.byte_count = '0;
        msg_if.final_word = 1'b0;
        hash_init();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) send_word(dir_tab[i]);

        // Fourteen and fifteen words already buffered force two compressions
        for (int f = 14; f <= 16; f++) begin
            for (int j = 0; j < f; j++) send_word('{rand64(), 4'($urandom_range(15)), 1'b0});
            send_word('{rand64(), 4'($urandom_range(15)), 1'b1});
        end

        // Sender holds off until all digests are out
        hold_input();
        wait (digest_q.size() == 0);

        // Random messages, mostly short, some multi-block
        n_sent = 0;
        n_msg = 0;
        while (n_sent < 300) begin
            no_idle = (n_msg >= 8 && n_msg < 14);
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
            for (int j = 0; j < len; j++) begin
                it.msg_word = rand64();
                it.byte_count = 4'($urandom_range(15));
                it.final_word = 1'b0;
                send_word(it);
            end
            it.msg_word = rand64();
            it.byte_count = 4'($urandom_range(15));
            it.final_word = 1'b1;
            send_word(it);
            n_sent += len + 1;
            n_msg++;
        end
        no_idle = 1'b0;
        hold_input();

        wait (digest_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sha512_hash_engine.f @@
sv/s512_pkg.sv
sv/s512_if.sv
sv/s512_ram.sv
sv/s512_round.sv
sv/sha512_hash_engine.sv
tb/sv/tb_sha512_hash_engine.sv
